// ===== sv/wufso_pkg.sv =====
package wufso_pkg;

    // Widths of the fields on the item and result channels.
    localparam int IDX_W    = 12;
    localparam int SIZE_W   = 13;
    localparam int CNT_W    = 4;
    localparam int NBR_PORTS = 8;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OCCUPIED = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;

    localparam logic ACT_OCCUPY = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

endpackage

// ===== sv/weighted_union_find_site_occupation.sv =====
// Weighted union-find engine over a table of SITES sites.
// The input channel (i_valid / o_stall) carries one transaction per item: an
// occupy (i_action = 0) names a new site and up to eight neighbors, a query
// (i_action = 1) names a site whose root and cluster size are wanted.
// The output channel (o_valid / i_stall) returns exactly one transaction per item
// with a status, the site's root and cluster size, and the largest-cluster record.
// All state lives in one table memory, one access of each kind per cycle, with
// a registered read, so the block works on one item at a time. A query of an
// empty site goes straight to the output; otherwise a query walks from the site
// to its root and then points each node of the path straight at the root. A
// rejected occupy walks to the root without rewriting the path, and a site
// outside the table goes straight to the output. A fresh occupy writes the site
// as a root and then takes its listed neighbors in turn: it skips one that is
// out of range or empty, and otherwise walks it to its root, compresses the path
// and, if the roots differ, hangs one under the other and rewrites the survivor's size.
// After reset the block sweeps the table clear, one entry per cycle; o_stall
// stays high during that sweep and whenever an item is at work.
// A finished result sits in the output register until the receiver takes it;
// the next item is accepted meanwhile, and holds in its last step only if the
// output register is still full when its own result is ready.
module weighted_union_find_site_occupation
    import wufso_pkg::*;
#(
    parameter int SITES         = 4096,
    parameter int MAX_NEIGHBORS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic [IDX_W-1:0]   i_site,
    input  logic [CNT_W-1:0]   i_nbr_count,
    input  logic [IDX_W-1:0]   i_nbr_a,
    input  logic [IDX_W-1:0]   i_nbr_b,
    input  logic [IDX_W-1:0]   i_nbr_c,
    input  logic [IDX_W-1:0]   i_nbr_d,
    input  logic [IDX_W-1:0]   i_nbr_e,
    input  logic [IDX_W-1:0]   i_nbr_f,
    input  logic [IDX_W-1:0]   i_nbr_g,
    input  logic [IDX_W-1:0]   i_nbr_h,

    output logic               o_valid,
    input  logic               i_stall,
    output t_status            o_status,
    output logic [IDX_W-1:0]   o_root_site,
    output logic [SIZE_W-1:0]  o_cluster_size,
    output logic [IDX_W-1:0]   o_largest_root,
    output logic [SIZE_W-1:0]  o_largest_size
);

    // Address width, and word width: a word holds a parent index or a size up to SITES.
    localparam int AW = $clog2(SITES);
    localparam int WW = AW + 1;
    localparam int NW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    // A table entry: occupied flag, root flag, and the parent or the cluster size.
    typedef struct packed {
        logic          used;
        logic          top;
        logic [WW-1:0] word;
    } t_entry;

    localparam int DW = $bits(t_entry);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_CHK   = 9'b000000100,
        S_NBR   = 9'b000001000,
        S_WALK  = 9'b000010000,
        S_SQ    = 9'b000100000,
        S_MRG1  = 9'b001000000,
        S_MRG2  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]    r_clr, n_clr;
    logic             r_act, n_act;
    logic [AW-1:0]    r_site, n_site;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_nbr [MAX_NEIGHBORS];
    logic [IDX_W-1:0] w_nbr_in [NBR_PORTS];

    // Walk state: start of the path, current node, root found and its size.
    logic [AW-1:0]    r_start, n_start;
    logic [AW-1:0]    r_cur, n_cur;
    logic [AW-1:0]    r_root, n_root;
    logic [WW-1:0]    r_rsize, n_rsize;
    logic             r_squash, n_squash;
    logic             r_nbr_mode, n_nbr_mode;

    // Root of the new site's cluster while neighbors are merged in.
    logic [AW-1:0]    r_r1, n_r1;
    logic [WW-1:0]    r_r1size, n_r1size;
    logic [WW-1:0]    r_sum, n_sum;

    logic [WW-1:0]    r_rec_size, n_rec_size;
    logic [AW-1:0]    r_rec_root, n_rec_root;

    // Result waiting for the output register, and the output register itself.
    t_status          r_res_status, n_res_status;
    logic [AW-1:0]    r_res_root, n_res_root;
    logic [WW-1:0]    r_res_size, n_res_size;

    logic             r_ovalid, n_ovalid;
    t_status          r_out_status, n_out_status;
    logic [AW-1:0]    r_out_root, n_out_root;
    logic [WW-1:0]    r_out_size, n_out_size;
    logic [AW-1:0]    r_out_lroot, n_out_lroot;
    logic [WW-1:0]    r_out_lsize, n_out_lsize;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    t_entry           w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [DW-1:0]    w_rdata;
    t_entry           w_rd;

    logic             w_accept;
    logic             w_site_ok;
    logic [IDX_W-1:0] w_nbr_cur;
    logic             w_nbr_ok;
    logic [AW-1:0]    w_parent;

    assign w_nbr_in[0] = i_nbr_a;
    assign w_nbr_in[1] = i_nbr_b;
    assign w_nbr_in[2] = i_nbr_c;
    assign w_nbr_in[3] = i_nbr_d;
    assign w_nbr_in[4] = i_nbr_e;
    assign w_nbr_in[5] = i_nbr_f;
    assign w_nbr_in[6] = i_nbr_g;
    assign w_nbr_in[7] = i_nbr_h;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);

    assign w_site_ok = (32'(i_site) < 32'(SITES));
    assign w_nbr_cur = r_nbr[r_j[NW-1:0]];
    assign w_nbr_ok  = (32'(w_nbr_cur) < 32'(SITES));

    assign w_rd     = t_entry'(w_rdata);
    assign w_parent = AW'(w_rd.word);

    wufso_table #(
        .DEPTH (SITES),
        .AW    (AW),
        .DW    (DW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_act        = r_act;
        n_site       = r_site;
        n_cnt        = r_cnt;
        n_j          = r_j;
        n_start      = r_start;
        n_cur        = r_cur;
        n_root       = r_root;
        n_rsize      = r_rsize;
        n_squash     = r_squash;
        n_nbr_mode   = r_nbr_mode;
        n_r1         = r_r1;
        n_r1size     = r_r1size;
        n_sum        = r_sum;
        n_rec_size   = r_rec_size;
        n_rec_root   = r_rec_root;
        n_res_status = r_res_status;
        n_res_root   = r_res_root;
        n_res_size   = r_res_size;
        n_ovalid     = r_ovalid && i_stall;
        n_out_status = r_out_status;
        n_out_root   = r_out_root;
        n_out_size   = r_out_size;
        n_out_lroot  = r_out_lroot;
        n_out_lsize  = r_out_lsize;

        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wdata = '0;
        w_raddr = r_cur;

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(SITES - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                w_raddr = AW'(i_site);
                if (w_accept) begin
                    n_act  = i_action;
                    n_site = AW'(i_site);
                    n_cnt  = (i_nbr_count > CNT_W'(MAX_NEIGHBORS)) ?
                             CNT_W'(MAX_NEIGHBORS) : i_nbr_count;
                    if (w_site_ok) begin
                        n_state = S_CHK;
                    end else begin
                        n_res_status = (i_action == ACT_QUERY) ? ST_EMPTY : ST_OCCUPIED;
                        n_res_root   = '0;
                        n_res_size   = '0;
                        n_state      = S_OUT;
                    end
                end
            end

            S_CHK: begin
                if (w_rd.used) begin
                    // Occupied site: walk to its root, compressing only for a query.
                    n_res_status = (r_act == ACT_QUERY) ? ST_OK : ST_OCCUPIED;
                    n_squash     = (r_act == ACT_QUERY);
                    n_nbr_mode   = 1'b0;
                    n_cur        = r_site;
                    n_start      = r_site;
                    w_raddr      = r_site;
                    n_state      = S_WALK;
                end else if (r_act == ACT_QUERY) begin
                    n_res_status = ST_EMPTY;
                    n_res_root   = '0;
                    n_res_size   = '0;
                    n_state      = S_OUT;
                end else begin
                    w_we         = 1'b1;
                    w_waddr      = r_site;
                    w_wdata      = '{used: 1'b1, top: 1'b1, word: WW'(1)};
                    n_res_status = ST_OK;
                    n_r1         = r_site;
                    n_r1size     = WW'(1);
                    n_j          = '0;
                    n_state      = S_NBR;
                end
            end

            S_NBR: begin
                if (r_j >= r_cnt) begin
                    n_res_root = r_r1;
                    n_res_size = r_r1size;
                    n_state    = S_OUT;
                end else if (!w_nbr_ok) begin
                    n_j = r_j + CNT_W'(1);
                end else begin
                    w_raddr    = AW'(w_nbr_cur);
                    n_cur      = AW'(w_nbr_cur);
                    n_start    = AW'(w_nbr_cur);
                    n_squash   = 1'b1;
                    n_nbr_mode = 1'b1;
                    n_state    = S_WALK;
                end
            end

            S_WALK: begin
                if (!w_rd.used) begin
                    // Only a neighbor's first read can find an empty site.
                    n_j     = r_j + CNT_W'(1);
                    n_state = S_NBR;
                end else if (w_rd.top) begin
                    n_root  = r_cur;
                    n_rsize = w_rd.word;
                    if (r_squash && (r_start != r_cur)) begin
                        n_cur   = r_start;
                        w_raddr = r_start;
                        n_state = S_SQ;
                    end else if (r_nbr_mode) begin
                        n_state = S_MRG1;
                    end else begin
                        n_res_root = r_cur;
                        n_res_size = w_rd.word;
                        n_state    = S_OUT;
                    end
                end else begin
                    n_cur   = w_parent;
                    w_raddr = w_parent;
                end
            end

            S_SQ: begin
                if ((r_cur != r_root) && !w_rd.top) begin
                    // Point this node straight at the root and move on to its old parent.
                    w_we    = 1'b1;
                    w_waddr = r_cur;
                    w_wdata = '{used: 1'b1, top: 1'b0, word: WW'(r_root)};
                    n_cur   = w_parent;
                    w_raddr = w_parent;
                end else if (r_nbr_mode) begin
                    n_state = S_MRG1;
                end else begin
                    n_res_root = r_root;
                    n_res_size = r_rsize;
                    n_state    = S_OUT;
                end
            end

            S_MRG1: begin
                if (r_root == r_r1) begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = S_NBR;
                end else begin
                    n_sum = r_r1size + r_rsize;
                    w_we  = 1'b1;
                    if (r_r1size < r_rsize) begin
                        w_waddr = r_r1;
                        w_wdata = '{used: 1'b1, top: 1'b0, word: WW'(r_root)};
                        n_r1    = r_root;
                    end else begin
                        // On a tie the neighbor's root goes under the new site's root.
                        w_waddr = r_root;
                        w_wdata = '{used: 1'b1, top: 1'b0, word: WW'(r_r1)};
                    end
                    n_state = S_MRG2;
                end
            end

            S_MRG2: begin
                w_we     = 1'b1;
                w_waddr  = r_r1;
                w_wdata  = '{used: 1'b1, top: 1'b1, word: r_sum};
                n_r1size = r_sum;
                if (r_sum > r_rec_size) begin
                    n_rec_size = r_sum;
                    n_rec_root = r_r1;
                end
                n_j     = r_j + CNT_W'(1);
                n_state = S_NBR;
            end

            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid     = 1'b1;
                    n_out_status = r_res_status;
                    n_out_root   = r_res_root;
                    n_out_size   = r_res_size;
                    n_out_lroot  = r_rec_root;
                    n_out_lsize  = r_rec_size;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_ovalid   <= 1'b0;
            r_rec_size <= '0;
            r_rec_root <= '0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_ovalid   <= n_ovalid;
            r_rec_size <= n_rec_size;
            r_rec_root <= n_rec_root;
        end

        if (w_accept) begin
            for (int k = 0; k < MAX_NEIGHBORS; k++) begin
                r_nbr[k] <= w_nbr_in[k];
            end
        end

        r_act        <= n_act;
        r_site       <= n_site;
        r_cnt        <= n_cnt;
        r_j          <= n_j;
        r_start      <= n_start;
        r_cur        <= n_cur;
        r_root       <= n_root;
        r_rsize      <= n_rsize;
        r_squash     <= n_squash;
        r_nbr_mode   <= n_nbr_mode;
        r_r1         <= n_r1;
        r_r1size     <= n_r1size;
        r_sum        <= n_sum;
        r_res_status <= n_res_status;
        r_res_root   <= n_res_root;
        r_res_size   <= n_res_size;
        r_out_status <= n_out_status;
        r_out_root   <= n_out_root;
        r_out_size   <= n_out_size;
        r_out_lroot  <= n_out_lroot;
        r_out_lsize  <= n_out_lsize;
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_out_status;
    assign o_root_site    = IDX_W'(r_out_root);
    assign o_cluster_size = SIZE_W'(r_out_size);
    assign o_largest_root = IDX_W'(r_out_lroot);
    assign o_largest_size = SIZE_W'(r_out_lsize);

endmodule

// ===== sv/wufso_table.sv =====
module wufso_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 15
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    // Simple dual-port table; a read of the address being written returns the old data.
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_data <= r_mem[i_raddr];
    end

    assign o_rdata = r_data;

endmodule
